// ===== rtl/sv48ptb_pkg.sv =====
// Shared constants for the SV48 page table builder.
package sv48ptb_pkg;

    localparam int unsigned ENTRY_BITS = 9;            // 512 entries per table
    localparam int unsigned PPN_W      = 44;
    localparam int unsigned PA_W       = 56;
    localparam logic [3:0]  SATP_MODE  = 4'd9;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_MAP   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_PTR = 2'd2,
        ST_NO_ROOT = 2'd3
    } status_t;

endpackage

// ===== rtl/sv48_page_table_builder_top.sv =====
// SV48 page table builder: command FSM around a single-port page table memory.
//
// Usage:
//  - Input beats on s_* carry one command each (tuser = command code):
//    start (empty pool, allocate and clear root), map region, read entry.
//  - Each command yields exactly one result beat on m_* with status, the read
//    entry (zero unless a read succeeds), satp and the pool fill count.
//  - pool_base_page is written over cfg_valid/cfg_ready/cfg_data; the user must
//    write it only while idle, the block itself does not enforce this.
//  - Answers that need no memory (no root, table out of range, unused code) go
//    straight to S_OUT; a read goes through S_RDE and S_RDE_W; start clears the
//    root one entry per cycle. Map: a pick per leaf, a read and check per table
//    level, a clear sweep per new table on the single port, then S_OUT.
//  - One command in flight at a time. A finished result sits in the output
//    register; the next command is taken while that beat waits. If a second
//    result is ready before the first is taken, the FSM holds until m_tready.
//  - Reset clears the fill count (no root), the pool base and the output
//    valid. Memory contents are undefined until a table is allocated; each
//    allocation clears its table before use.
module sv48_page_table_builder_top #(
    parameter int TABLE_COUNT = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config: pool_base_page [43:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [43:0]  cfg_data,
    // in: region_start[55:0] region_end[111:56] permissions[119:112]
    //     table_number[129:120] entry_number[138:130], zero pad above
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    // out: status[1:0] entry_value[65:2] satp_value[129:66]
    //      tables_in_use[140:130], zero pad above
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata
);

    localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int CW    = $clog2(TABLE_COUNT + 1);
    localparam int AW    = TW + sv48ptb_pkg::ENTRY_BITS;
    localparam int DEPTH = TABLE_COUNT * (1 << sv48ptb_pkg::ENTRY_BITS);
    localparam int CURW  = sv48ptb_pkg::PA_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_PICK, S_RD, S_CHK, S_RDE, S_RDE_W, S_OUT
    } state_t;

    state_t state_reg;

    logic [43:0]      base_reg;
    logic [CW-1:0]    alloc_reg;
    logic [7:0]       perm_reg;
    logic [9:0]       tn_reg;
    logic [8:0]       en_reg;
    logic [CURW-1:0]  cur_reg;
    logic [CURW-1:0]  end_reg;
    logic [1:0]       level_reg;
    logic [1:0]       leaf_reg;
    logic [TW-1:0]    tab_reg;
    logic [TW-1:0]    clr_tab_reg;
    logic [8:0]       clr_cnt_reg;
    logic             clr_walk_reg;
    logic [1:0]       status_reg;
    logic [63:0]      entry_reg;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [63:0]      m_entry_reg;
    logic [63:0]      m_satp_reg;
    logic [10:0]      m_count_reg;

    // page table memory
    logic [63:0]      mem [DEPTH];
    logic [63:0]      mem_rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [63:0]      mem_wdata;

    logic [47:0]      va;
    logic [8:0]       idx;
    logic [CURW-1:0]  rem;
    logic [43:0]      off;
    logic             entry_valid;
    logic             pool_full;
    logic             s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, m_count_reg, m_satp_reg, m_entry_reg, m_status_reg};

    // Virtual address = physical + 0xFFFF800000000000; low 48 bits flip bit 47.
    assign va  = {~cur_reg[47], cur_reg[46:0]};
    assign rem = end_reg - cur_reg;
    assign off = mem_rdata_reg[53:10] - base_reg;
    assign entry_valid = mem_rdata_reg[0];
    assign pool_full   = (alloc_reg >= CW'(TABLE_COUNT));

    always_comb begin
        case (level_reg)
            2'd3:    idx = va[47:39];
            2'd2:    idx = va[38:30];
            2'd1:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = {tab_reg, idx};
        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = {clr_tab_reg, clr_cnt_reg};
            end
            S_CHK: begin
                if (level_reg == leaf_reg) begin
                    if (!(leaf_reg == 2'd0 && entry_valid)) begin
                        mem_we    = 1'b1;
                        mem_wdata = {10'b0, cur_reg[55:12], 2'b00, perm_reg | 8'h01};
                    end
                end else if (!entry_valid && !pool_full) begin
                    mem_we    = 1'b1;
                    mem_wdata = {10'b0, base_reg + 44'(alloc_reg), 9'b0, 1'b1};
                end
            end
            S_RDE:   mem_addr = {TW'(tn_reg), en_reg};
            default: mem_addr = {tab_reg, idx};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            alloc_reg   <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        perm_reg   <= s_tdata[119:112];
                        tn_reg     <= s_tdata[129:120];
                        en_reg     <= s_tdata[138:130];
                        entry_reg  <= '0;
                        status_reg <= sv48ptb_pkg::ST_OK;
                        // round start up and end down to 4 KiB
                        cur_reg <= (CURW'(s_tdata[55:0]) + CURW'(12'hFFF))
                                   & ~CURW'(12'hFFF);
                        end_reg <= CURW'(s_tdata[111:56]) & ~CURW'(12'hFFF);
                        state_reg <= S_OUT;
                        case (s_tuser)
                            sv48ptb_pkg::CMD_START: begin
                                alloc_reg    <= CW'(1);
                                clr_tab_reg  <= '0;
                                clr_cnt_reg  <= '0;
                                clr_walk_reg <= 1'b0;
                                state_reg    <= S_CLEAR;
                            end
                            sv48ptb_pkg::CMD_MAP: begin
                                if (alloc_reg == '0) begin
                                    status_reg <= sv48ptb_pkg::ST_NO_ROOT;
                                end else begin
                                    state_reg <= S_PICK;
                                end
                            end
                            sv48ptb_pkg::CMD_READ: begin
                                if (alloc_reg == '0) begin
                                    status_reg <= sv48ptb_pkg::ST_NO_ROOT;
                                end else if (17'(s_tdata[129:120]) >= 17'(alloc_reg)) begin
                                    status_reg <= sv48ptb_pkg::ST_BAD_PTR;
                                end else begin
                                    state_reg <= S_RDE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 9'd1;
                    if (clr_cnt_reg == 9'h1FF) begin
                        state_reg <= clr_walk_reg ? S_RD : S_OUT;
                    end
                end
                S_PICK: begin
                    level_reg <= 2'd3;
                    tab_reg   <= '0;
                    if (cur_reg < end_reg) begin
                        state_reg <= S_RD;
                        if (cur_reg[29:0] == '0 && rem >= (CURW'(1) << 30)) begin
                            leaf_reg <= 2'd2;
                        end else if (cur_reg[20:0] == '0 && rem >= (CURW'(1) << 21)) begin
                            leaf_reg <= 2'd1;
                        end else begin
                            leaf_reg <= 2'd0;
                        end
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_RD: state_reg <= S_CHK;
                S_CHK: begin
                    if (level_reg == leaf_reg) begin
                        case (leaf_reg)
                            2'd2:    cur_reg <= cur_reg + (CURW'(1) << 30);
                            2'd1:    cur_reg <= cur_reg + (CURW'(1) << 21);
                            default: cur_reg <= cur_reg + (CURW'(1) << 12);
                        endcase
                        state_reg <= S_PICK;
                    end else if (entry_valid) begin
                        // existing pointer: decode back to a pool index
                        if (off >= 44'(alloc_reg)) begin
                            status_reg <= sv48ptb_pkg::ST_BAD_PTR;
                            state_reg  <= S_OUT;
                        end else begin
                            tab_reg   <= off[TW-1:0];
                            level_reg <= level_reg - 2'd1;
                            state_reg <= S_RD;
                        end
                    end else if (pool_full) begin
                        status_reg <= sv48ptb_pkg::ST_FULL;
                        state_reg  <= S_OUT;
                    end else begin
                        // pointer written this cycle; clear the new table next
                        alloc_reg    <= alloc_reg + CW'(1);
                        clr_tab_reg  <= alloc_reg[TW-1:0];
                        clr_cnt_reg  <= '0;
                        clr_walk_reg <= 1'b1;
                        tab_reg      <= alloc_reg[TW-1:0];
                        level_reg    <= level_reg - 2'd1;
                        state_reg    <= S_CLEAR;
                    end
                end
                S_RDE:   state_reg <= S_RDE_W;
                S_RDE_W: begin
                    entry_reg <= mem_rdata_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_entry_reg  <= entry_reg;
                        m_satp_reg   <= (alloc_reg != '0)
                                        ? {sv48ptb_pkg::SATP_MODE, 16'd0, base_reg} : '0;
                        m_count_reg  <= 11'(alloc_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // fill count never passes the pool size
    a_alloc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_reg <= CW'(TABLE_COUNT))
        else $error("pool count above pool size");

    // a start command leaves exactly the root allocated
    a_start_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == sv48ptb_pkg::CMD_START) |=> alloc_reg == CW'(1))
        else $error("start did not allocate root");

    // walk only visits allocated tables
    a_walk_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (CW'(tab_reg) < alloc_reg))
        else $error("walk in unallocated table");

    // no memory write while idle
    a_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");

endmodule
